// File: design/sar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sar_pkg;

  // Default geometry of the atlas
  localparam int DEF_INITIAL_SIZE = 512;
  localparam int DEF_MAX_SIZE     = 4096;
  localparam int DEF_PAD          = 1;
  localparam int DEF_EPOCH_BITS   = 16;

  // Fixed field widths of the ports
  localparam int RECT_W      = 12;
  localparam int POS_W       = 12;
  localparam int SIZE_OUT_W  = 13;
  localparam int EPOCH_OUT_W = 16;

  // Footprint width: request plus padding on both sides
  localparam int FOOT_W = 13;

  // Operation codes of the shared arithmetic unit
  typedef enum logic {
    ALU_ADD,  // res = a + b, flag = (res <= c)
    ALU_MAX   // res = max(a, b), flag = (a >= b)
  } alu_op_t;

endpackage

`default_nettype wire

// File: design/sar_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module sar_alu
  import sar_pkg::*;
#(
  parameter int W = 14
) (
  input  alu_op_t        op,
  input  logic [W-1:0]   op_a,
  input  logic [W-1:0]   op_b,
  input  logic [W-1:0]   op_c,
  output logic [W-1:0]   res,
  output logic           flag
);

  logic [W-1:0] sum;
  logic         a_ge_b;

  // One adder and two comparators, shared by the fit, close, tall, test and place steps
  assign sum    = op_a + op_b;
  assign a_ge_b = (op_a >= op_b);

  always_comb begin
    case (op)
      ALU_ADD: begin
        res  = sum;
        flag = (sum <= op_c);
      end
      ALU_MAX: begin
        res  = a_ge_b ? op_a : op_b;
        flag = a_ge_b;
      end
      default: begin
        res  = '0;
        flag = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/shelf_atlas_rect_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Handshake
// request   in_rect_width, in_rect_height           start & !busy accepts
// result    out_placed .. out_did_wipe              out_valid, one cycle
//
// A placement without growth runs the fit, tall, test and place steps after
// accept, plus a close step if the shelf closes, one shared adder/comparator
// step per cycle. Each grow or wipe retry runs the grow step and starts over.
// busy is high from accept until the result strobe; results cannot be held
// off. Reset (rst_n low, synchronous) restores the initial atlas size,
// an empty packer and a zero epoch.

module shelf_atlas_rect_allocator
  import sar_pkg::*;
#(
  parameter int INITIAL_SIZE = DEF_INITIAL_SIZE,
  parameter int MAX_SIZE     = DEF_MAX_SIZE,
  parameter int PAD          = DEF_PAD,
  parameter int EPOCH_BITS   = DEF_EPOCH_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output      logic                   busy,
  input  wire logic [RECT_W-1:0]      in_rect_width,
  input  wire logic [RECT_W-1:0]      in_rect_height,
  output      logic                   out_valid,
  output      logic                   out_placed,
  output      logic [POS_W-1:0]       out_pos_x,
  output      logic [POS_W-1:0]       out_pos_y,
  output      logic [SIZE_OUT_W-1:0]  out_atlas_width,
  output      logic [SIZE_OUT_W-1:0]  out_atlas_height,
  output      logic [EPOCH_OUT_W-1:0] out_epoch_count,
  output      logic                   out_did_grow,
  output      logic                   out_did_wipe
);

  localparam int MAXV = (INITIAL_SIZE > MAX_SIZE) ? INITIAL_SIZE : MAX_SIZE;
  localparam int SZ_W = $clog2(MAXV + 1);
  localparam int CW   = ((SZ_W > FOOT_W) ? SZ_W : FOOT_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FITW,
    S_FITP,
    S_CLOSE,
    S_TALL,
    S_TEST,
    S_PLACE,
    S_GROW
  } state_t;

  state_t                  state_r,   state_nxt;
  logic [SZ_W-1:0]         atlas_w_r, atlas_w_nxt;
  logic [SZ_W-1:0]         atlas_h_r, atlas_h_nxt;
  logic [SZ_W-1:0]         top_r,     top_nxt;
  logic [SZ_W-1:0]         shelf_r,   shelf_nxt;
  logic [SZ_W-1:0]         pen_r,     pen_nxt;
  logic [EPOCH_BITS-1:0]   epoch_r,   epoch_nxt;
  logic [FOOT_W-1:0]       fw_r,      fw_nxt;
  logic [FOOT_W-1:0]       fh_r,      fh_nxt;
  logic [CW-1:0]           tall_r,    tall_nxt;
  logic                    grew_r,    grew_nxt;
  logic                    wiped_r,   wiped_nxt;

  logic                    ov_r,      ov_nxt;
  logic                    placed_r,  placed_nxt;
  logic [POS_W-1:0]        px_r,      px_nxt;
  logic [POS_W-1:0]        py_r,      py_nxt;

  alu_op_t                 alu_op;
  logic [CW-1:0]           alu_a, alu_b, alu_c, alu_res;
  logic                    alu_flag;

  logic [CW-1:0]           dbl_w, dbl_h, max_c;
  logic                    at_max;
  logic [CW-1:0]           px_full, py_full;

  sar_alu #(.W(CW)) u_alu (
    .op   (alu_op),
    .op_a (alu_a),
    .op_b (alu_b),
    .op_c (alu_c),
    .res  (alu_res),
    .flag (alu_flag)
  );

  // Operand selection for the shared unit
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = CW'(fw_r);
    alu_c  = CW'(atlas_w_r);
    case (state_r)
      S_FITW: begin
        alu_a = '0;
      end
      S_FITP, S_PLACE: begin
        alu_a = CW'(pen_r);
      end
      S_CLOSE: begin
        alu_a = CW'(top_r);
        alu_b = CW'(shelf_r);
      end
      S_TALL: begin
        alu_op = ALU_MAX;
        alu_a  = CW'(shelf_r);
        alu_b  = CW'(fh_r);
      end
      S_TEST: begin
        alu_a = CW'(top_r);
        alu_b = tall_r;
        alu_c = CW'(atlas_h_r);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // Grow step: double the shorter axis, clamped to the maximum
  assign max_c   = CW'(MAX_SIZE);
  assign dbl_w   = CW'(atlas_w_r) << 1;
  assign dbl_h   = CW'(atlas_h_r) << 1;
  assign at_max  = (CW'(atlas_w_r) >= max_c) && (CW'(atlas_h_r) >= max_c);
  assign px_full = CW'(pen_r) + CW'(PAD);
  assign py_full = CW'(top_r) + CW'(PAD);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    atlas_w_nxt = atlas_w_r;
    atlas_h_nxt = atlas_h_r;
    top_nxt     = top_r;
    shelf_nxt   = shelf_r;
    pen_nxt     = pen_r;
    epoch_nxt   = epoch_r;
    fw_nxt      = fw_r;
    fh_nxt      = fh_r;
    tall_nxt    = tall_r;
    grew_nxt    = grew_r;
    wiped_nxt   = wiped_r;
    ov_nxt      = 1'b0;
    placed_nxt  = placed_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          fw_nxt    = FOOT_W'(in_rect_width) + FOOT_W'(2 * PAD);
          fh_nxt    = FOOT_W'(in_rect_height) + FOOT_W'(2 * PAD);
          grew_nxt  = 1'b0;
          wiped_nxt = 1'b0;
          state_nxt = S_FITW;
        end
      end
      S_FITW: begin
        state_nxt = alu_flag ? S_FITP : S_GROW;
      end
      S_FITP: begin
        state_nxt = alu_flag ? S_TALL : S_CLOSE;
      end
      S_CLOSE: begin
        top_nxt   = alu_res[SZ_W-1:0];
        shelf_nxt = '0;
        pen_nxt   = '0;
        state_nxt = S_TALL;
      end
      S_TALL: begin
        tall_nxt  = alu_res;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        state_nxt = alu_flag ? S_PLACE : S_GROW;
      end
      S_PLACE: begin
        px_nxt     = px_full[POS_W-1:0];
        py_nxt     = py_full[POS_W-1:0];
        pen_nxt    = alu_res[SZ_W-1:0];
        shelf_nxt  = tall_r[SZ_W-1:0];
        placed_nxt = 1'b1;
        ov_nxt     = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_GROW: begin
        if (at_max && wiped_r) begin
          // second failure at full size: report and stay wiped
          px_nxt     = '0;
          py_nxt     = '0;
          placed_nxt = 1'b0;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          if (at_max) begin
            wiped_nxt = 1'b1;
          end else begin
            grew_nxt = 1'b1;
            if (atlas_w_r <= atlas_h_r) begin
              atlas_w_nxt = (dbl_w > max_c) ? max_c[SZ_W-1:0] : dbl_w[SZ_W-1:0];
            end else begin
              atlas_h_nxt = (dbl_h > max_c) ? max_c[SZ_W-1:0] : dbl_h[SZ_W-1:0];
            end
          end
          top_nxt   = '0;
          shelf_nxt = '0;
          pen_nxt   = '0;
          epoch_nxt = epoch_r + EPOCH_BITS'(1);
          state_nxt = S_FITW;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      atlas_w_r <= SZ_W'(INITIAL_SIZE);
      atlas_h_r <= SZ_W'(INITIAL_SIZE);
      top_r     <= '0;
      shelf_r   <= '0;
      pen_r     <= '0;
      epoch_r   <= '0;
      grew_r    <= 1'b0;
      wiped_r   <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      atlas_w_r <= atlas_w_nxt;
      atlas_h_r <= atlas_h_nxt;
      top_r     <= top_nxt;
      shelf_r   <= shelf_nxt;
      pen_r     <= pen_nxt;
      epoch_r   <= epoch_nxt;
      grew_r    <= grew_nxt;
      wiped_r   <= wiped_nxt;
      ov_r      <= ov_nxt;
    end
    fw_r     <= fw_nxt;
    fh_r     <= fh_nxt;
    tall_r   <= tall_nxt;
    placed_r <= placed_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
  end

  // Output view; sizes and epoch are masked to the port widths
  logic [31:0] aw_ext, ah_ext, ep_ext;

  assign aw_ext = 32'(atlas_w_r);
  assign ah_ext = 32'(atlas_h_r);
  assign ep_ext = 32'(epoch_r);

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_placed       = placed_r;
  assign out_pos_x        = px_r;
  assign out_pos_y        = py_r;
  assign out_atlas_width  = aw_ext[SIZE_OUT_W-1:0];
  assign out_atlas_height = ah_ext[SIZE_OUT_W-1:0];
  assign out_epoch_count  = ep_ext[EPOCH_OUT_W-1:0];
  assign out_did_grow     = grew_r;
  assign out_did_wipe     = wiped_r;

endmodule

`default_nettype wire

// File: design/sar_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sar_checker
  import sar_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic [RECT_W-1:0]      in_rect_width,
  input wire logic [RECT_W-1:0]      in_rect_height,
  input wire logic                   out_valid,
  input wire logic                   out_placed,
  input wire logic [POS_W-1:0]       out_pos_x,
  input wire logic [POS_W-1:0]       out_pos_y,
  input wire logic [SIZE_OUT_W-1:0]  out_atlas_width,
  input wire logic [SIZE_OUT_W-1:0]  out_atlas_height,
  input wire logic [EPOCH_OUT_W-1:0] out_epoch_count,
  input wire logic                   out_did_grow,
  input wire logic                   out_did_wipe
);

  // An accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result is strobed once, with the block already idle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy ##1 !out_valid))
    else $error("result strobe longer than one cycle or while busy");

  // No result without a transaction in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !out_valid)
    else $error("result strobe without a transaction");

  // A failed request reports the origin and always involves a wipe
  a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_placed) |->
      (out_pos_x == '0 && out_pos_y == '0 && out_did_wipe))
    else $error("failed request with bad position or no wipe");

endmodule

bind shelf_atlas_rect_allocator sar_checker u_sar_checker (.*);

`default_nettype wire

// File: tb/shelf_atlas_rect_allocator_tb.sv
`timescale 1ns / 1ps

module shelf_atlas_rect_allocator_tb;
  import sar_pkg::*;

  localparam int IDLE_LIMIT   = 1000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES = 64;    // worst case: six grows, a wipe and a retry
  localparam int RANDOM_ITEMS = 900;
  localparam int MAX_REPORTS  = 10;
  localparam int DIRECTED_N   = 22;

  typedef struct packed {
    logic                   placed;
    logic [POS_W-1:0]       pos_x;
    logic [POS_W-1:0]       pos_y;
    logic [SIZE_OUT_W-1:0]  atlas_width;
    logic [SIZE_OUT_W-1:0]  atlas_height;
    logic [EPOCH_OUT_W-1:0] epoch;
    logic                   did_grow;
    logic                   did_wipe;
  } placement_t;

  typedef struct packed {
    logic [RECT_W-1:0] w;
    logic [RECT_W-1:0] h;
    logic              typed;  // row carries its own expected placement
    placement_t        exp;
  } rect_row_t;

  localparam placement_t NO_EXP = '0;

  // Directed requests: reset state, shelf closes, grows on both axes, exact fits,
  // wipe at maximum size, failures and recovery after a failure.
  localparam rect_row_t DIRECTED [DIRECTED_N] = '{
    '{12'd0,    12'd0,    1'b1, '{1'b1, 12'd1, 12'd1, 13'd512, 13'd512, 16'd0, 1'b0, 1'b0}},
    '{12'd1,    12'd1,    1'b1, '{1'b1, 12'd3, 12'd1, 13'd512, 13'd512, 16'd0, 1'b0, 1'b0}},
    '{12'd509,  12'd1,    1'b0, NO_EXP},
    '{12'd1,    12'd509,  1'b0, NO_EXP},
    '{12'd600,  12'd10,   1'b0, NO_EXP},
    '{12'd10,   12'd600,  1'b0, NO_EXP},
    '{12'd1022, 12'd1,    1'b0, NO_EXP},
    '{12'd100,  12'd1000, 1'b0, NO_EXP},
    '{12'haaa,  12'h555,  1'b0, NO_EXP},
    '{12'h555,  12'haaa,  1'b0, NO_EXP},
    '{12'd2000, 12'd2000, 1'b0, NO_EXP},
    '{12'd3000, 12'd100,  1'b0, NO_EXP},
    '{12'd4094, 12'd4094, 1'b0, NO_EXP},
    '{12'd4094, 12'd1,    1'b0, NO_EXP},
    '{12'd0,    12'd0,    1'b0, NO_EXP},
    '{12'd4095, 12'd4095, 1'b0, NO_EXP},
    '{12'd0,    12'd0,    1'b0, NO_EXP},
    '{12'd4095, 12'd0,    1'b0, NO_EXP},
    '{12'd0,    12'd4095, 1'b0, NO_EXP},
    '{12'd4094, 12'd0,    1'b0, NO_EXP},
    '{12'd2047, 12'd2047, 1'b0, NO_EXP},
    '{12'd2048, 12'd2048, 1'b0, NO_EXP}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [RECT_W-1:0]      in_rect_width;
  logic [RECT_W-1:0]      in_rect_height;
  logic                   out_valid;
  logic                   out_placed;
  logic [POS_W-1:0]       out_pos_x;
  logic [POS_W-1:0]       out_pos_y;
  logic [SIZE_OUT_W-1:0]  out_atlas_width;
  logic [SIZE_OUT_W-1:0]  out_atlas_height;
  logic [EPOCH_OUT_W-1:0] out_epoch_count;
  logic                   out_did_grow;
  logic                   out_did_wipe;

  shelf_atlas_rect_allocator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .out_valid        (out_valid),
    .out_placed       (out_placed),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_atlas_width  (out_atlas_width),
    .out_atlas_height (out_atlas_height),
    .out_epoch_count  (out_epoch_count),
    .out_did_grow     (out_did_grow),
    .out_did_wipe     (out_did_wipe)
  );

  always #2 clk = ~clk;

  // Shadow copy of the packer state
  int unsigned                atlas_w_q;
  int unsigned                atlas_h_q;
  int unsigned                shelf_top_q;
  int unsigned                shelf_tall_q;
  int unsigned                pen_x_q;
  logic [DEF_EPOCH_BITS-1:0]  epoch_q;

  placement_t pending_results [$];
  int         mismatch_count;
  int         idle_cycles;

  // Empty the packer; every grow and wipe moves the epoch on
  function automatic void clear_packer();
    shelf_top_q  = 0;
    shelf_tall_q = 0;
    pen_x_q      = 0;
    epoch_q      = epoch_q + 1'b1;
  endfunction

  // Place one request, growing and wiping as needed; updates the shadow state
  function automatic placement_t place_rect(input logic [RECT_W-1:0] w,
                                            input logic [RECT_W-1:0] h);
    int unsigned fw;
    int unsigned fh;
    int unsigned tall;
    int unsigned px;
    int unsigned py;
    int unsigned dbl;
    bit          grew;
    bit          wiped;
    bit          ok;
    bit          done;
    placement_t  r;
    fw    = 32'(w) + 2 * DEF_PAD;
    fh    = 32'(h) + 2 * DEF_PAD;
    grew  = 1'b0;
    wiped = 1'b0;
    ok    = 1'b0;
    done  = 1'b0;
    px    = 0;
    py    = 0;
    while (!done) begin
      if (fw <= atlas_w_q) begin
        // close the shelf when the footprint runs past the right edge
        if (pen_x_q + fw > atlas_w_q) begin
          shelf_top_q  = shelf_top_q + shelf_tall_q;
          shelf_tall_q = 0;
          pen_x_q      = 0;
        end
        tall = (shelf_tall_q > fh) ? shelf_tall_q : fh;
        if (shelf_top_q + tall <= atlas_h_q) begin
          px           = pen_x_q + DEF_PAD;
          py           = shelf_top_q + DEF_PAD;
          pen_x_q      = pen_x_q + fw;
          shelf_tall_q = tall;
          ok           = 1'b1;
          done         = 1'b1;
        end
      end
      if (!done) begin
        if (!(atlas_w_q >= DEF_MAX_SIZE && atlas_h_q >= DEF_MAX_SIZE)) begin
          // double the shorter axis, width on a tie
          if (atlas_w_q <= atlas_h_q) begin
            dbl       = atlas_w_q * 2;
            atlas_w_q = (dbl > DEF_MAX_SIZE) ? DEF_MAX_SIZE : dbl;
          end else begin
            dbl       = atlas_h_q * 2;
            atlas_h_q = (dbl > DEF_MAX_SIZE) ? DEF_MAX_SIZE : dbl;
          end
          clear_packer();
          grew = 1'b1;
        end else if (wiped) begin
          done = 1'b1;
        end else begin
          wiped = 1'b1;
          clear_packer();
        end
      end
    end
    r.placed       = ok;
    r.pos_x        = px[POS_W-1:0];
    r.pos_y        = py[POS_W-1:0];
    r.atlas_width  = atlas_w_q[SIZE_OUT_W-1:0];
    r.atlas_height = atlas_h_q[SIZE_OUT_W-1:0];
    r.epoch        = EPOCH_OUT_W'(epoch_q);
    r.did_grow     = grew;
    r.did_wipe     = wiped;
    return r;
  endfunction

  // Random dimension: mostly small, some medium and large, a few extremes
  function automatic logic [RECT_W-1:0] rand_dim();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 10)      return RECT_W'($urandom_range(0, 127));
    else if (sel < 16) return RECT_W'($urandom_range(128, 1023));
    else if (sel < 19) return RECT_W'($urandom_range(1024, 4095));
    else               return RECT_W'($urandom);
  endfunction

  // Present one request and hold it until accepted; leaves start high
  task automatic send_rect(input logic [RECT_W-1:0] w, input logic [RECT_W-1:0] h,
                           input logic typed, input placement_t exp);
    placement_t pred;
    in_rect_width  <= w;
    in_rect_height <= h;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    pred = place_rect(w, h);
    pending_results.insert(pending_results.size(), typed ? exp : pred);
  endtask

  // Sender gap: lowers start only when there is a gap
  task automatic sender_gap(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Result checker and idle watchdog
  always @(posedge clk) begin
    placement_t act;
    placement_t exp;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid) begin
        act = '{out_placed, out_pos_x, out_pos_y, out_atlas_width, out_atlas_height,
                out_epoch_count, out_did_grow, out_did_wipe};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result transaction: placed=%0d x=%0d y=%0d",
                     act.placed, act.pos_x, act.pos_y);
        end else begin
          exp = pending_results.pop_front();
          if (act !== exp) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch exp: placed=%0d x=%0d y=%0d w=%0d h=%0d ep=%0d g=%0d wp=%0d",
                       exp.placed, exp.pos_x, exp.pos_y, exp.atlas_width,
                       exp.atlas_height, exp.epoch, exp.did_grow, exp.did_wipe);
              $display("         act: placed=%0d x=%0d y=%0d w=%0d h=%0d ep=%0d g=%0d wp=%0d",
                       act.placed, act.pos_x, act.pos_y, act.atlas_width,
                       act.atlas_height, act.epoch, act.did_grow, act.did_wipe);
            end
          end
        end
      end
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned burst_left;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_rect_width  = '0;
    in_rect_height = '0;
    mismatch_count = 0;
    atlas_w_q      = DEF_INITIAL_SIZE;
    atlas_h_q      = DEF_INITIAL_SIZE;
    shelf_top_q    = 0;
    shelf_tall_q   = 0;
    pen_x_q        = 0;
    epoch_q        = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, back to back with occasional gaps
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_rect(DIRECTED[i].w, DIRECTED[i].h, DIRECTED[i].typed, DIRECTED[i].exp);
      if (i % 5 == 4) sender_gap($urandom_range(1, 7));
    end

    // random requests in bursts of random length
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_rect(rand_dim(), rand_dim(), 1'b0, NO_EXP);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 20));
      end
    end
    start <= 1'b0;

    // drain outstanding results, then watch for stray strobes
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
